[src/ship_srrip_stream_replacement_defines.svh]
// assertion macros for the replacement policy block
// no dependencies
`ifndef SHIP_SRRIP_STREAM_REPLACEMENT_DEFINES_SVH
`define SHIP_SRRIP_STREAM_REPLACEMENT_DEFINES_SVH
`ifndef SYNTHESIS
`define SSR_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error("lbl");
`define SSR_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error("lbl");
`else
`define SSR_ASSERT_IMP(lbl, clk, rstn, a, c)
`define SSR_ASSERT_NXT(lbl, clk, rstn, a, c)
`endif
`endif

[src/ssr_pkg.sv]
// shared types and constants for the replacement policy block
// no dependencies
`default_nettype none
package ssr_pkg;
  localparam int NUM_SETS_D      = 2048;
  localparam int NUM_WAYS_D      = 16;
  localparam int TABLE_ENTRIES_D = 2048;
  localparam int ADDR_BITS_D     = 48;
  localparam logic [1:0] MAX_AGE = 2'd3;
  localparam logic [10:0] SET_HASH_MASK = 11'h7FF;

  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_STRIDE    = 2'd1;
  localparam logic [1:0] CFG_WINDOW    = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_t;
endpackage
`default_nettype wire

[src/ship_srrip_stream_replacement.sv]
// replacement policy top level: srrip ages, signature counters, stream detector
// depends on ssr_pkg and ship_srrip_stream_replacement_defines.svh
// result strobe registered from the read state; items are taken only in idle, after read
// and write-back, plus a decrement step when a streaming fill lowers the evicted
// signature's counter; reset: a clearing pass over max(NUM_SETS, TABLE_ENTRIES) entries
// runs after reset, busy stays high during it; the receiver cannot stall
`default_nettype none
`include "ship_srrip_stream_replacement_defines.svh"
module ship_srrip_stream_replacement #(
  parameter int NUM_SETS      = ssr_pkg::NUM_SETS_D,
  parameter int NUM_WAYS      = ssr_pkg::NUM_WAYS_D,
  parameter int TABLE_ENTRIES = ssr_pkg::TABLE_ENTRIES_D,
  parameter int ADDR_BITS     = ssr_pkg::ADDR_BITS_D
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 in_cmd,
  input  wire logic [10:0]          in_set_index,
  input  wire logic [3:0]           in_way,
  input  wire logic [5:0]           in_pc_signature,
  input  wire logic [ADDR_BITS-1:0] in_address,
  input  wire logic                 in_hit,
  output logic                      out_valid,
  output logic [3:0]                out_victim_way,
  output logic                      out_set_streaming,
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [15:0]          cfg_data
);
  localparam int SB = $clog2(NUM_SETS);
  localparam int WB = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int TB = $clog2(TABLE_ENTRIES);
  localparam int CB = (SB > TB) ? SB + 1 : TB + 1;
  localparam int CLR = (NUM_SETS > TABLE_ENTRIES) ? NUM_SETS : TABLE_ENTRIES;
  localparam int HB = (TB > 11) ? TB : 11;

  // set row: ages, signatures, last address, score
  typedef struct packed {
    logic [NUM_WAYS-1:0][1:0] age;
    logic [NUM_WAYS-1:0][5:0] sig;
    logic [ADDR_BITS-1:0]     last;
    logic signed [4:0]        score;
  } row_t;

  row_t set_mem [NUM_SETS];
  logic [1:0] ctr_mem [TABLE_ENTRIES];

  ssr_pkg::state_t state_r, state_nxt;
  logic [CB-1:0] clr_r, clr_nxt;
  logic [3:0]  thr_r;
  logic [11:0] stride_r;
  logic [15:0] window_r;

  logic              cmd_r, hit_r;
  logic [SB-1:0]     set_r;
  logic [WB-1:0]     way_r;
  logic [5:0]        sig_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [TB-1:0]     idx_r;

  row_t       row_q;
  logic [1:0] ctr_q;

  logic          valid_r;
  logic [3:0]    vic_r;
  logic          strm_r;

  logic [SB-1:0] set_in;
  logic [WB-1:0] way_in;
  logic [HB-1:0] hash_in;
  logic          accept;

  assign set_in = SB'(in_set_index);
  assign way_in = WB'(32'(in_way) % NUM_WAYS);
  assign hash_in = HB'({5'd0, in_pc_signature} ^ (in_set_index & ssr_pkg::SET_HASH_MASK));
  assign accept = start && !busy;

  // row write-back and counter increment
  row_t          row_w;
  logic          ctr_we;
  logic [1:0]    ctr_wd;
  logic [WB-1:0] vic_w;
  logic          strm_w;

  logic [1:0]           oldest;
  logic [1:0]           bump;
  logic [ADDR_BITS-1:0] delta;
  logic signed [5:0]    sc;
  logic signed [5:0]    th;
  logic [5:0]           osig;
  logic [HB-1:0]        vhash;
  logic [1:0]           nage;
  logic                 found;

  always_comb begin
    row_w  = row_q;
    ctr_we = 1'b0;
    ctr_wd = ctr_q;
    vic_w  = '0;
    found  = 1'b0;
    oldest = 2'd0;
    bump   = 2'd0;
    delta  = '0;
    sc     = 6'(row_q.score);
    th     = 6'(signed'({2'b00, thr_r}));
    osig   = row_q.sig[way_r];
    vhash  = HB'({5'd0, osig} ^ 11'(set_r));
    nage   = 2'd0;
    if (!cmd_r) begin
      for (int w = 0; w < NUM_WAYS; w++)
        if (row_q.age[w] > oldest) oldest = row_q.age[w];
      bump = ssr_pkg::MAX_AGE - oldest;
      for (int w = 0; w < NUM_WAYS; w++) begin
        row_w.age[w] = row_q.age[w] + bump;
        if (!found && row_w.age[w] == ssr_pkg::MAX_AGE) begin
          found = 1'b1;
          vic_w = WB'(w);
        end
      end
      strm_w = (row_q.score >= signed'({1'b0, thr_r}));
    end else begin
      if (row_q.last != '0)
        delta = (addr_r >= row_q.last) ? addr_r - row_q.last : row_q.last - addr_r;
      if (delta == ADDR_BITS'(stride_r)) sc = sc + 6'sd1;
      else if (delta != '0 && delta < ADDR_BITS'(window_r)) sc = sc - 6'sd1;
      if (sc > th) sc = th;
      if (sc < -th) sc = -th;
      row_w.score = 5'(sc);
      row_w.last  = addr_r;
      strm_w = (sc >= th);
      row_w.sig[way_r] = sig_r;
      if (hit_r) begin
        row_w.age[way_r] = 2'd0;
        ctr_we = (ctr_q != ssr_pkg::MAX_AGE);
        ctr_wd = ctr_q + 2'd1;
      end else begin
        if (strm_w) nage = ssr_pkg::MAX_AGE;
        else if (ctr_q >= 2'd2) nage = 2'd0;
        else nage = 2'd2;
        row_w.age[way_r] = nage;
        // evicted signature's counter is read by a second lookup and lowered in the write state
      end
    end
  end

  // second phase for fill decrement: counter at the old signature index
  logic          dec_pend_r;
  logic [TB-1:0] dec_idx_r;
  logic [1:0]    dec_q;

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      ssr_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CB'(CLR - 1)) state_nxt = ssr_pkg::ST_IDLE;
      end
      ssr_pkg::ST_IDLE:  if (accept) state_nxt = ssr_pkg::ST_READ;
      ssr_pkg::ST_READ:  state_nxt = ssr_pkg::ST_WRITE;
      ssr_pkg::ST_WRITE: state_nxt = dec_pend_r ? ssr_pkg::ST_WRITE : ssr_pkg::ST_IDLE;
      default:           state_nxt = ssr_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    busy = (state_r != ssr_pkg::ST_IDLE);
  end

  logic dec_start;
  assign dec_start = (state_r == ssr_pkg::ST_READ) && cmd_r && !hit_r &&
                     strm_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ssr_pkg::ST_CLEAR;
      clr_r      <= '0;
      thr_r      <= 4'd8;
      stride_r   <= 12'd64;
      window_r   <= 16'd4096;
      valid_r    <= 1'b0;
      dec_pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          ssr_pkg::CFG_THRESHOLD: thr_r    <= cfg_data[3:0];
          ssr_pkg::CFG_STRIDE:    stride_r <= cfg_data[11:0];
          ssr_pkg::CFG_WINDOW:    window_r <= cfg_data;
          default: ;
        endcase
      end
      valid_r <= (state_r == ssr_pkg::ST_READ);
      if (dec_start) dec_pend_r <= 1'b1;
      else if (state_r == ssr_pkg::ST_WRITE) dec_pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      hit_r  <= in_hit;
      set_r  <= set_in;
      way_r  <= way_in;
      sig_r  <= in_pc_signature;
      addr_r <= in_address;
      idx_r  <= TB'(hash_in);
    end
    if (state_r == ssr_pkg::ST_READ) begin
      vic_r     <= 4'(vic_w);
      strm_r    <= strm_w;
      dec_idx_r <= TB'(vhash);
    end
  end

  // set memory: read on accept, write in read-result cycle
  always_ff @(posedge clk) begin
    if (state_r == ssr_pkg::ST_CLEAR) begin
      if (clr_r < CB'(NUM_SETS))
        set_mem[SB'(clr_r)] <= '{age: {NUM_WAYS{ssr_pkg::MAX_AGE}}, sig: '0,
                                 last: '0, score: '0};
    end else if (state_r == ssr_pkg::ST_READ) begin
      set_mem[set_r] <= row_w;
    end
    row_q <= set_mem[set_in];
  end

  // counter memory: a single write port (clear, increment, decrement) and two read lookups
  always_ff @(posedge clk) begin
    if (state_r == ssr_pkg::ST_CLEAR) begin
      if (clr_r < CB'(TABLE_ENTRIES)) ctr_mem[TB'(clr_r)] <= 2'd1;
    end else if (state_r == ssr_pkg::ST_READ && ctr_we) begin
      ctr_mem[idx_r] <= ctr_wd;
    end else if (state_r == ssr_pkg::ST_WRITE && dec_pend_r && dec_q != 2'd0) begin
      ctr_mem[dec_idx_r] <= dec_q - 2'd1;
    end
    ctr_q <= ctr_mem[TB'(hash_in)];
    dec_q <= ctr_mem[TB'(vhash)];
  end

  assign out_valid         = valid_r;
  assign out_victim_way    = cmd_r ? 4'd0 : vic_r;
  assign out_set_streaming = strm_r;

  `SSR_ASSERT_NXT(a_strobe_after_read, clk, rst_n, state_r == ssr_pkg::ST_READ, out_valid)
  `SSR_ASSERT_IMP(a_no_accept_busy, clk, rst_n, out_valid, busy)
  `SSR_ASSERT_IMP(a_update_zero_way, clk, rst_n, out_valid && cmd_r, out_victim_way == 4'd0)
endmodule
`default_nettype wire

[verif/tb.sv]
// testbench for ship_srrip_stream_replacement: directed and random victim/update items
// checked against an in-bench model of ages, signature counters and stream scores
// depends on ssr_pkg and the block's rtl
`timescale 1ns / 1ps
module tb;
  typedef struct packed {
    logic [3:0] victim_way;
    logic       streaming;
  } policy_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_cmd = 1'b0;
  logic [10:0] in_set_index = '0;
  logic [3:0]  in_way = '0;
  logic [5:0]  in_pc_signature = '0;
  logic [47:0] in_address = '0;
  logic        in_hit = 1'b0;
  logic        out_valid;
  logic [3:0]  out_victim_way;
  logic        out_set_streaming;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic [1:0]  age_mem [ssr_pkg::NUM_SETS_D][ssr_pkg::NUM_WAYS_D];
  logic [5:0]  sig_mem [ssr_pkg::NUM_SETS_D][ssr_pkg::NUM_WAYS_D];
  logic [1:0]  reuse_ctr [ssr_pkg::TABLE_ENTRIES_D];
  logic [47:0] prev_addr_mdl [ssr_pkg::NUM_SETS_D];
  int          score_mdl [ssr_pkg::NUM_SETS_D];
  logic [3:0]  thr_reg;
  logic [11:0] stride_reg;
  logic [15:0] window_reg;

  policy_result_t pending_q[$];
  int err_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit idle_en = 1'b1;

  always #6 clk = ~clk;

  ship_srrip_stream_replacement u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_set_index(in_set_index), .in_way(in_way),
    .in_pc_signature(in_pc_signature), .in_address(in_address), .in_hit(in_hit),
    .out_valid(out_valid), .out_victim_way(out_victim_way),
    .out_set_streaming(out_set_streaming),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic logic is_streaming(int s);
    return score_mdl[s] >= int'(thr_reg);
  endfunction

  function automatic int hash_index(logic [5:0] sig, int s);
    return int'({5'd0, sig} ^ (s[10:0] & ssr_pkg::SET_HASH_MASK)) % ssr_pkg::TABLE_ENTRIES_D;
  endfunction

  function automatic policy_result_t apply_access(logic cmd, logic [10:0] set_in,
      logic [3:0] way_in, logic [5:0] sig, logic [47:0] addr, logic hit);
    policy_result_t r;
    int s, w, th, sc, idx, vidx;
    logic [1:0] oldest, nage;
    logic [47:0] delta;
    s = int'(set_in) % ssr_pkg::NUM_SETS_D;
    w = int'(way_in) % ssr_pkg::NUM_WAYS_D;
    r = '0;
    if (cmd == 1'b0) begin
      oldest = 2'd0;
      for (int i = 0; i < ssr_pkg::NUM_WAYS_D; i++)
        if (age_mem[s][i] > oldest) oldest = age_mem[s][i];
      for (int i = 0; i < ssr_pkg::NUM_WAYS_D; i++)
        age_mem[s][i] = age_mem[s][i] + (ssr_pkg::MAX_AGE - oldest);
      for (int i = ssr_pkg::NUM_WAYS_D - 1; i >= 0; i--)
        if (age_mem[s][i] == ssr_pkg::MAX_AGE) r.victim_way = 4'(i);
      r.streaming = is_streaming(s);
      return r;
    end
    th = int'(thr_reg);
    sc = score_mdl[s];
    delta = '0;
    if (prev_addr_mdl[s] != '0)
      delta = (addr >= prev_addr_mdl[s]) ? addr - prev_addr_mdl[s] : prev_addr_mdl[s] - addr;
    if (delta == {36'd0, stride_reg}) sc++;
    else if (delta != '0 && delta < {32'd0, window_reg}) sc--;
    if (sc > th) sc = th;
    if (sc < -th) sc = -th;
    score_mdl[s] = sc;
    prev_addr_mdl[s] = addr;
    idx = hash_index(sig, s);
    if (hit) begin
      age_mem[s][w] = 2'd0;
      sig_mem[s][w] = sig;
      if (reuse_ctr[idx] < ssr_pkg::MAX_AGE) reuse_ctr[idx]++;
    end else begin
      vidx = hash_index(sig_mem[s][w], s);
      if (is_streaming(s)) nage = ssr_pkg::MAX_AGE;
      else if (reuse_ctr[idx] >= 2'd2) nage = 2'd0;
      else nage = 2'd2;
      sig_mem[s][w] = sig;
      age_mem[s][w] = nage;
      if (nage == ssr_pkg::MAX_AGE && reuse_ctr[vidx] > 2'd0) reuse_ctr[vidx]--;
    end
    r.streaming = is_streaming(s);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    err_count++;
    $display("tb: mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic send_item(logic cmd, logic [10:0] set_in, logic [3:0] way_in,
      logic [5:0] sig, logic [47:0] addr, logic hit);
    int gap;
    if (idle_en && $urandom_range(99) < 20) begin
      gap = $urandom_range(4, 1);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    start <= 1'b1;
    in_cmd <= cmd;
    in_set_index <= set_in;
    in_way <= way_in;
    in_pc_signature <= sig;
    in_address <= addr;
    in_hit <= hit;
    do @(posedge clk); while (busy);
    pending_q.push_back(apply_access(cmd, set_in, way_in, sig, addr, hit));
    items_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ssr_pkg::CFG_THRESHOLD: thr_reg = val[3:0];
      ssr_pkg::CFG_STRIDE:    stride_reg = val[11:0];
      ssr_pkg::CFG_WINDOW:    window_reg = val;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch("result with nothing pending");
      end else begin
        if (out_victim_way !== pending_q[0].victim_way)
          report_mismatch($sformatf("victim_way %0d, want %0d",
                                    out_victim_way, pending_q[0].victim_way));
        if (out_set_streaming !== pending_q[0].streaming)
          report_mismatch($sformatf("set_streaming %0b, want %0b",
                                    out_set_streaming, pending_q[0].streaming));
        void'(pending_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= 20000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_directed;
    send_item(1'b0, 11'd0, 4'd0, 6'd0, 48'd0, 1'b0);
    send_item(1'b1, 11'd0, 4'd0, 6'h3F, 48'h1000, 1'b0);
    send_item(1'b1, 11'd0, 4'd5, 6'h3F, 48'h1040, 1'b1);
    send_item(1'b1, 11'd0, 4'd6, 6'h3F, 48'h1080, 1'b1);
    send_item(1'b0, 11'd0, 4'd0, 6'd0, 48'd0, 1'b0);
    send_item(1'b1, 11'd0, 4'd0, 6'd1, 48'h1090, 1'b0);
    send_item(1'b1, 11'd2047, 4'd15, 6'h3F, 48'hFFFF_FFFF_FFFF, 1'b1);
    send_item(1'b1, 11'd2047, 4'd15, 6'h00, 48'hFFFF_FFFF_FFBF, 1'b1);
    send_item(1'b1, 11'd2047, 4'd3, 6'h2A, 48'h0, 1'b0);
    send_item(1'b0, 11'd2047, 4'd0, 6'd0, 48'd0, 1'b0);
    for (int i = 0; i < 11; i++)
      send_item(1'b1, 11'd9, 4'(i), 6'h15, 48'h4000 + 48'(i) * 48'd64, 1'b0);
    send_item(1'b0, 11'd9, 4'd0, 6'd0, 48'd0, 1'b0);
    send_item(1'b1, 11'd9, 4'd2, 6'h15, 48'h9000_0000, 1'b0);
  endtask

  task automatic random_run(int count);
    int s, w;
    logic [47:0] a;
    logic [11:0] step;
    for (int n = 0; n < count; n++) begin
      idle_en = !(n >= count / 3 && n < count / 2);
      s = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(7);
      case ($urandom_range(9))
        0: send_item(1'($urandom_range(1)), 11'($urandom), 4'($urandom), 6'($urandom),
                     48'({$urandom, $urandom}), 1'($urandom_range(1)));
        1, 2, 3: begin
          a = prev_addr_mdl[s];
          step = ($urandom_range(3) == 0) ? 12'($urandom_range(4095, 1)) : stride_reg;
          repeat ($urandom_range(6, 2)) begin
            a = ($urandom_range(7) == 0) ? a - 48'(step) : a + 48'(step);
            send_item(1'b1, 11'(s), 4'($urandom), 6'($urandom), a, 1'($urandom_range(1)));
          end
        end
        4, 5, 6: begin
          send_item(1'b0, 11'(s), 4'($urandom), 6'($urandom), 48'({$urandom, $urandom}),
                    1'b0);
          w = pending_q[$].victim_way;
          send_item(1'b1, 11'(s), 4'(w), 6'($urandom_range(7)),
                    prev_addr_mdl[s] + 48'($urandom_range(8191)), 1'b0);
        end
        default: send_item(1'b1, 11'(s), 4'($urandom), 6'($urandom_range(7)),
                           prev_addr_mdl[s] + 48'($urandom_range(300)), 1'b1);
      endcase
    end
    idle_en = 1'b1;
  endtask

  task automatic test_config_extremes;
    write_cfg(ssr_pkg::CFG_THRESHOLD, 16'd1);
    write_cfg(ssr_pkg::CFG_STRIDE, 16'd1);
    write_cfg(ssr_pkg::CFG_WINDOW, 16'd1);
    random_run(90);
    write_cfg(ssr_pkg::CFG_THRESHOLD, 16'd15);
    write_cfg(ssr_pkg::CFG_STRIDE, 16'd4095);
    write_cfg(ssr_pkg::CFG_WINDOW, 16'd65535);
    random_run(90);
    write_cfg(ssr_pkg::CFG_THRESHOLD, 16'd0);
    random_run(45);
    write_cfg(ssr_pkg::CFG_THRESHOLD, 16'd3);
    write_cfg(ssr_pkg::CFG_STRIDE, 16'd8);
    write_cfg(ssr_pkg::CFG_WINDOW, 16'd600);
    random_run(90);
  endtask

  task automatic test_random_defaults;
    write_cfg(ssr_pkg::CFG_THRESHOLD, 16'd8);
    write_cfg(ssr_pkg::CFG_STRIDE, 16'd64);
    write_cfg(ssr_pkg::CFG_WINDOW, 16'd4096);
    random_run(335);
  endtask

  initial begin
    for (int s = 0; s < ssr_pkg::NUM_SETS_D; s++) begin
      for (int w = 0; w < ssr_pkg::NUM_WAYS_D; w++) begin
        age_mem[s][w] = ssr_pkg::MAX_AGE;
        sig_mem[s][w] = '0;
      end
      prev_addr_mdl[s] = '0;
      score_mdl[s] = 0;
    end
    for (int i = 0; i < ssr_pkg::TABLE_ENTRIES_D; i++) reuse_ctr[i] = 2'd1;
    thr_reg = 4'd8;
    stride_reg = 12'd64;
    window_reg = 16'd4096;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_extremes();
    test_random_defaults();
    drain();
    $display("tb: %0d items sent, %0d results checked, %0d mismatches", items_sent,
             results_seen, err_count);
    $display("tb: covered victim aging, hit/fill inserts, stream scoring, threshold 0..15");
    if (err_count == 0 && pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
